>>> hdl/iirnb_pkg.sv
// Package for the notch biquad: fixed-point widths, microcode control word and program.
`default_nettype none

package iirnb_pkg;

  // Block geometry and fixed-point format.
  localparam int BLOCK_LEN      = 256;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = 18;
  localparam int ADC_BITS       = 12;
  localparam int OUT_BITS       = 16;
  localparam int NUM_REGS       = 5;
  localparam int REG_IDX_BITS   = 3;
  localparam int STATE_BITS     = 20 + COEF_FRAC_BITS;

  // The state word is multiplied in two halves: low half unsigned, high half signed.
  localparam int LO_BITS   = (STATE_BITS + 1) / 2;
  localparam int HI_BITS   = STATE_BITS - LO_BITS;
  localparam int OP_BITS   = LO_BITS + 1;
  localparam int PROD_BITS = COEF_BITS + OP_BITS;

  // Output accumulator holds three full products and reaches above the 16-bit result.
  localparam int ACC_SUM_BITS = COEF_BITS + STATE_BITS + 2;
  localparam int ACC_OUT_BITS = 2 * COEF_FRAC_BITS + OUT_BITS + 2;
  localparam int ACC_BITS     = (ACC_SUM_BITS > ACC_OUT_BITS) ? ACC_SUM_BITS : ACC_OUT_BITS;

  // Feedback sum: input term minus two shifted feedback products, at least one bit above the state.
  localparam int WACC_MIN  = COEF_BITS + 22;
  localparam int WACC_BITS = (STATE_BITS + 1 > WACC_MIN) ? STATE_BITS + 1 : WACC_MIN;

  localparam int CNT_BITS  = $clog2(BLOCK_LEN);
  localparam int STEP_BITS = 4;

  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [STATE_BITS-1:0] state_t;
  typedef logic signed [OP_BITS-1:0]    opnd_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;
  typedef logic signed [WACC_BITS-1:0]  wacc_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [STEP_BITS-1:0]         step_t;

  localparam cnt_t LAST_CNT = CNT_BITS'(BLOCK_LEN - 1);

  // Register indexes of the configuration port.
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    18'sd59139, -18'sd36550, 18'sd59139, -18'sd36550, 18'sd52743
  };

  typedef enum logic [1:0] {
    SRC_W1 = 2'd0,
    SRC_W2 = 2'd1,
    SRC_W  = 2'd2
  } src_sel_t;

  typedef enum logic {
    HALF_LO = 1'b0,
    HALF_HI = 1'b1
  } half_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    W_HOLD = 2'd0,
    W_INIT = 2'd1,
    W_SUB  = 2'd2,
    W_SAT  = 2'd3
  } w_op_t;

  typedef enum logic [1:0] {
    CND_ALWAYS = 2'd0,
    CND_IN     = 2'd1,
    CND_OUT    = 2'd2
  } cond_t;

  typedef struct packed {
    reg_idx_t coef;
    src_sel_t src;
    half_t    half;
    acc_op_t  acc;
    w_op_t    wop;
    cond_t    cond;
    logic     fin;
    step_t    target;
  } ctrl_t;

  localparam step_t STEP_WAIT = 4'd0;
  localparam step_t STEP_DONE = 4'd11;

  function automatic ctrl_t word(input reg_idx_t coef, input src_sel_t src, input half_t half,
                                 input acc_op_t acc, input w_op_t wop, input cond_t cond,
                                 input logic fin, input step_t target);
    ctrl_t c;
    c.coef   = coef;
    c.src    = src;
    c.half   = half;
    c.acc    = acc;
    c.wop    = wop;
    c.cond   = cond;
    c.fin    = fin;
    c.target = target;
    return c;
  endfunction

  // Each step issues one half-product; steps 1 to 10 load or add the one issued in the step before.
  function automatic ctrl_t ucode(input step_t s);
    step_t nx;
    nx = step_t'(s + 1'b1);
    unique case (s)
      4'd0:  return word(REG_A1, SRC_W1, HALF_LO, ACC_HOLD, W_INIT, CND_IN,     1'b0, nx);
      4'd1:  return word(REG_A1, SRC_W1, HALF_HI, ACC_LOAD, W_HOLD, CND_ALWAYS, 1'b0, nx);
      4'd2:  return word(REG_A2, SRC_W2, HALF_LO, ACC_ADD,  W_HOLD, CND_ALWAYS, 1'b0, nx);
      4'd3:  return word(REG_A2, SRC_W2, HALF_HI, ACC_LOAD, W_SUB,  CND_ALWAYS, 1'b0, nx);
      4'd4:  return word(REG_B1, SRC_W1, HALF_LO, ACC_ADD,  W_HOLD, CND_ALWAYS, 1'b0, nx);
      4'd5:  return word(REG_B1, SRC_W1, HALF_HI, ACC_LOAD, W_SUB,  CND_ALWAYS, 1'b0, nx);
      4'd6:  return word(REG_B2, SRC_W2, HALF_LO, ACC_ADD,  W_SAT,  CND_ALWAYS, 1'b0, nx);
      4'd7:  return word(REG_B2, SRC_W2, HALF_HI, ACC_ADD,  W_HOLD, CND_ALWAYS, 1'b0, nx);
      4'd8:  return word(REG_B0, SRC_W,  HALF_LO, ACC_ADD,  W_HOLD, CND_ALWAYS, 1'b0, nx);
      4'd9:  return word(REG_B0, SRC_W,  HALF_HI, ACC_ADD,  W_HOLD, CND_ALWAYS, 1'b0, nx);
      4'd10: return word(REG_B0, SRC_W,  HALF_HI, ACC_ADD,  W_HOLD, CND_ALWAYS, 1'b0, nx);
      STEP_DONE: return word(REG_B0, SRC_W, HALF_HI, ACC_HOLD, W_HOLD, CND_OUT, 1'b1,
                             STEP_WAIT);
      default: return word(REG_B0, SRC_W, HALF_HI, ACC_HOLD, W_HOLD, CND_ALWAYS, 1'b0,
                           STEP_WAIT);
    endcase
  endfunction

endpackage

`default_nettype wire

>>> hdl/iir_notch_biquad_filter.sv
// Direct-form-II notch biquad run by a microcoded sequencer around one shared multiplier.
// An input beat is accepted only in the wait step; its result is registered on the output register
// when the last step fires. One sample is taken per pass of the twelve-step microprogram, which
// pushes ten 18x19 half-products through the single multiplier and accumulator.
// A waiting result does not block the next input beat; only a second finished result waits.
// Reset (rst_n low, synchronous) loads default coefficients, clears delay line and counter.
`default_nettype none

module iir_notch_biquad_filter (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [iirnb_pkg::ADC_BITS-1:0]         in_adc_sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [iirnb_pkg::OUT_BITS-1:0]              out_filtered_sample,
  output logic                                        out_block_end,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [iirnb_pkg::REG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [iirnb_pkg::COEF_BITS-1:0]        cfg_data
);

  iirnb_pkg::ctrl_t  ctrl;
  logic              cond_met;
  logic              fin_fire;
  logic              cnt_last;
  iirnb_pkg::step_t  step_r, step_nxt;
  iirnb_pkg::coef_t  coef_r [iirnb_pkg::NUM_REGS];
  iirnb_pkg::coef_t  mul_coef;
  iirnb_pkg::state_t mul_src;
  iirnb_pkg::opnd_t  mul_opnd;
  iirnb_pkg::prod_t  prod_r, prod_nxt;
  logic              prod_hi_r;
  iirnb_pkg::acc_t   prod_ext, acc_term, acc_shr;
  iirnb_pkg::acc_t   acc_r, acc_nxt;
  iirnb_pkg::wacc_t  wacc_r, wacc_nxt;
  iirnb_pkg::state_t w_r, w_nxt;
  iirnb_pkg::state_t w1_r, w1_nxt, w2_r, w2_nxt;
  iirnb_pkg::cnt_t   cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [iirnb_pkg::OUT_BITS-1:0] res_val, out_sample_r;
  logic              out_end_r;

  assign ctrl      = iirnb_pkg::ucode(step_r);
  assign cfg_ready = 1'b1;
  assign in_stall  = (ctrl.cond != iirnb_pkg::CND_IN);

  always_comb begin
    unique case (ctrl.cond)
      iirnb_pkg::CND_ALWAYS: cond_met = 1'b1;
      iirnb_pkg::CND_IN:     cond_met = in_valid;
      iirnb_pkg::CND_OUT:    cond_met = !out_valid_r || !out_stall;
      default:               cond_met = 1'b0;
    endcase
  end

  assign fin_fire = ctrl.fin && cond_met;
  assign step_nxt = cond_met ? ctrl.target : step_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl.coef)
      iirnb_pkg::REG_B0: mul_coef = coef_r[0];
      iirnb_pkg::REG_B1: mul_coef = coef_r[1];
      iirnb_pkg::REG_B2: mul_coef = coef_r[2];
      iirnb_pkg::REG_A1: mul_coef = coef_r[3];
      iirnb_pkg::REG_A2: mul_coef = coef_r[4];
      default:           mul_coef = coef_r[0];
    endcase
    unique case (ctrl.src)
      iirnb_pkg::SRC_W1: mul_src = w1_r;
      iirnb_pkg::SRC_W2: mul_src = w2_r;
      iirnb_pkg::SRC_W:  mul_src = w_r;
      default:           mul_src = w_r;
    endcase
    if (ctrl.half == iirnb_pkg::HALF_LO) begin
      mul_opnd = {1'b0, mul_src[iirnb_pkg::LO_BITS-1:0]};
    end else begin
      mul_opnd = {{(iirnb_pkg::OP_BITS - iirnb_pkg::HI_BITS){mul_src[iirnb_pkg::STATE_BITS-1]}},
                  mul_src[iirnb_pkg::STATE_BITS-1:iirnb_pkg::LO_BITS]};
    end
  end

  assign prod_nxt = mul_coef * mul_opnd;

  // High half-products carry the weight of the low half of the state word.
  always_comb begin
    prod_ext = {{(iirnb_pkg::ACC_BITS - iirnb_pkg::PROD_BITS){prod_r[iirnb_pkg::PROD_BITS-1]}},
                prod_r};
    acc_term = prod_hi_r ? (prod_ext <<< iirnb_pkg::LO_BITS) : prod_ext;
    unique case (ctrl.acc)
      iirnb_pkg::ACC_HOLD: acc_nxt = acc_r;
      iirnb_pkg::ACC_LOAD: acc_nxt = acc_term;
      iirnb_pkg::ACC_ADD:  acc_nxt = acc_r + acc_term;
      default:             acc_nxt = acc_r;
    endcase
  end

  // Feedback path: each product is floored by the fraction width before it is subtracted.
  assign acc_shr = acc_r >>> iirnb_pkg::COEF_FRAC_BITS;

  always_comb begin
    wacc_nxt = wacc_r;
    w_nxt    = w_r;
    unique case (ctrl.wop)
      iirnb_pkg::W_HOLD: begin
      end
      iirnb_pkg::W_INIT: begin
        wacc_nxt = {{(iirnb_pkg::WACC_BITS - iirnb_pkg::ADC_BITS - iirnb_pkg::COEF_FRAC_BITS)
                     {1'b0}}, in_adc_sample, {iirnb_pkg::COEF_FRAC_BITS{1'b0}}};
      end
      iirnb_pkg::W_SUB: begin
        wacc_nxt = wacc_r - acc_shr[iirnb_pkg::WACC_BITS-1:0];
      end
      iirnb_pkg::W_SAT: begin
        if (&wacc_r[iirnb_pkg::WACC_BITS-1:iirnb_pkg::STATE_BITS-1] ||
            ~|wacc_r[iirnb_pkg::WACC_BITS-1:iirnb_pkg::STATE_BITS-1]) begin
          w_nxt = wacc_r[iirnb_pkg::STATE_BITS-1:0];
        end else if (wacc_r[iirnb_pkg::WACC_BITS-1]) begin
          w_nxt = {1'b1, {(iirnb_pkg::STATE_BITS-1){1'b0}}};
        end else begin
          w_nxt = {1'b0, {(iirnb_pkg::STATE_BITS-1){1'b1}}};
        end
      end
      default: begin
      end
    endcase
  end

  // Integer part of the Q.2F output sum, clamped to the unsigned 16-bit range.
  always_comb begin
    priority if (acc_r[iirnb_pkg::ACC_BITS-1]) begin
      res_val = '0;
    end else if (|acc_r[iirnb_pkg::ACC_BITS-2:
                        2*iirnb_pkg::COEF_FRAC_BITS+iirnb_pkg::OUT_BITS]) begin
      res_val = '1;
    end else begin
      res_val = acc_r[2*iirnb_pkg::COEF_FRAC_BITS+iirnb_pkg::OUT_BITS-1:
                      2*iirnb_pkg::COEF_FRAC_BITS];
    end
  end

  assign cnt_last = (cnt_r == iirnb_pkg::LAST_CNT);

  always_comb begin
    w1_nxt  = w1_r;
    w2_nxt  = w2_r;
    cnt_nxt = cnt_r;
    if (fin_fire) begin
      if (cnt_last) begin
        w1_nxt  = '0;
        w2_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        w1_nxt  = w_r;
        w2_nxt  = w1_r;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= iirnb_pkg::STEP_WAIT;
      w1_r        <= '0;
      w2_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < iirnb_pkg::NUM_REGS; i++) begin
        coef_r[i] <= iirnb_pkg::COEF_RESET[i];
      end
    end else begin
      step_r      <= step_nxt;
      w1_r        <= w1_nxt;
      w2_r        <= w2_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && (cfg_index < iirnb_pkg::REG_IDX_BITS'(iirnb_pkg::NUM_REGS))) begin
        coef_r[cfg_index] <= cfg_data;
      end
    end
  end

  // Datapath registers; the microprogram sets every one before it is read.
  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    prod_hi_r <= (ctrl.half == iirnb_pkg::HALF_HI);
    acc_r     <= acc_nxt;
    wacc_r    <= wacc_nxt;
    w_r       <= w_nxt;
    if (fin_fire) begin
      out_sample_r <= res_val;
      out_end_r    <= cnt_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;
  assign out_block_end       = out_end_r;

endmodule

`default_nettype wire
